// ----- rtl/tspc_pkg.sv -----
// Shared types, constants and the coil sequence table for the three-axis stepper controller.
`default_nettype none
package tspc_pkg;

  localparam int POSITION_BITS = 10;
  localparam int LIMIT_W       = 10;
  localparam int TARGET_W      = 10;
  localparam int NUM_AXES      = 3;
  localparam int AXIS_W        = 2;
  localparam int PHASE_W       = 2;
  localparam int DRIVE_W       = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;
  localparam int CMP_W         = (POSITION_BITS > LIMIT_W) ?
                                 ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) :
                                 ((LIMIT_W > TARGET_W) ? LIMIT_W : TARGET_W);
  localparam int POS_MAX       = (1 << POSITION_BITS) - 1;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_Z = 2'd3;

  localparam logic [LIMIT_W-1:0] TOP_RST_X = 10'd800;
  localparam logic [LIMIT_W-1:0] TOP_RST_Y = 10'd800;
  localparam logic [LIMIT_W-1:0] TOP_RST_Z = 10'd1000;

  localparam logic [DRIVE_W-1:0] DRIVE_OFF = 4'h0;

  typedef struct packed {
    logic step;
    logic set;
    logic sw_clear;
  } axis_ctl_t;

  function automatic logic [DRIVE_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [DRIVE_W-1:0] pat;
    case (ph)
      2'd0:    pat = 4'h9;
      2'd1:    pat = 4'h5;
      2'd2:    pat = 4'h6;
      default: pat = 4'ha;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tspc_axis.sv -----
// One stepper axis: position, target, phase, reached flag and drive nibble.
`default_nettype none
module tspc_axis (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  tspc_pkg::axis_ctl_t                  ctl,
  input  wire [tspc_pkg::POSITION_BITS-1:0]    target_in,
  input  wire [tspc_pkg::LIMIT_W-1:0]          top_limit,
  output logic [tspc_pkg::DRIVE_W-1:0]         drive_nxt,
  output logic                                 reached_nxt
);
  import tspc_pkg::*;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] tgt_r, tgt_nxt;
  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  logic                     reached_r;
  logic [DRIVE_W-1:0]       drive_r;
  logic                     at_top;

  assign at_top = CMP_W'(pos_r) >= CMP_W'(top_limit);

  always_comb begin
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    phase_nxt   = phase_r;
    reached_nxt = reached_r;
    drive_nxt   = drive_r;
    if (ctl.set) begin
      tgt_nxt     = target_in;
      reached_nxt = 1'b0;
    end else if (ctl.step) begin
      if (tgt_r > pos_r) begin
        reached_nxt = 1'b0;
        if (!at_top) begin
          phase_nxt = phase_r + PHASE_W'(1);
          drive_nxt = coil_pattern(phase_nxt);
          pos_nxt   = pos_r + POSITION_BITS'(1);
        end
      end else if (tgt_r < pos_r) begin
        reached_nxt = 1'b0;
        if (at_top || ctl.sw_clear) begin
          phase_nxt = phase_r - PHASE_W'(1);
          drive_nxt = coil_pattern(phase_nxt);
          pos_nxt   = pos_r - POSITION_BITS'(1);
        end
      end else begin
        if (!reached_r)
          drive_nxt = DRIVE_OFF;
        reached_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      tgt_r     <= '0;
      phase_r   <= '0;
      reached_r <= 1'b0;
      drive_r   <= DRIVE_OFF;
    end else begin
      pos_r     <= pos_nxt;
      tgt_r     <= tgt_nxt;
      phase_r   <= phase_nxt;
      reached_r <= reached_nxt;
      drive_r   <= drive_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/three_axis_stepper_position_controller.sv -----
// Top level of the three-axis full-step stepper position controller.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid/in_ready    mode, axis, target_value, bottom_switches
//   out_*        output     out_valid/out_ready  drive_x/y/z, all_reached, target_accepted
//   cfg_*        input      cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle unless a full output register is stalled by out_ready: axis
// state updates at input acceptance and the result lands in the output register on the same edge.
// in_ready is high whenever the output register is empty or being drained.
// Reset is synchronous; it restores the default limits and zeroes all axes.
`default_nettype none
module three_axis_stepper_position_controller (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_mode,
  input  wire [tspc_pkg::AXIS_W-1:0]           in_axis,
  input  wire [tspc_pkg::TARGET_W-1:0]         in_target_value,
  input  wire [tspc_pkg::NUM_AXES-1:0]         in_bottom_switches,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [tspc_pkg::DRIVE_W-1:0]         out_drive_x,
  output logic [tspc_pkg::DRIVE_W-1:0]         out_drive_y,
  output logic [tspc_pkg::DRIVE_W-1:0]         out_drive_z,
  output logic                                 out_all_reached,
  output logic                                 out_target_accepted,
  input  wire                                  cfg_we,
  input  wire [tspc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [tspc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import tspc_pkg::*;

  logic               hold_r;
  logic [LIMIT_W-1:0] lim_r [NUM_AXES];
  logic               out_valid_r;
  logic [DRIVE_W-1:0] drive_x_r, drive_y_r, drive_z_r;
  logic               all_reached_r, accepted_r;

  logic               accept;
  logic [LIMIT_W-1:0] lim_sel;
  logic               axis_ok, set_ok, tick;
  logic [DRIVE_W-1:0] drive_nxt [NUM_AXES];
  logic [NUM_AXES-1:0] reached_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    axis_ok = 1'b1;
    lim_sel = lim_r[0];
    case (in_axis)
      2'd0:    lim_sel = lim_r[0];
      2'd1:    lim_sel = lim_r[1];
      2'd2:    lim_sel = lim_r[2];
      default: axis_ok = 1'b0;
    endcase
  end

  assign set_ok = accept && (in_mode == MODE_SET) && axis_ok &&
                  (CMP_W'(in_target_value) <= CMP_W'(lim_sel)) &&
                  (CMP_W'(in_target_value) <= CMP_W'(POS_MAX));
  assign tick   = accept && (in_mode == MODE_TICK) && !hold_r;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    axis_ctl_t ctl;
    assign ctl.step     = tick;
    assign ctl.set      = set_ok && (in_axis == AXIS_W'(g));
    assign ctl.sw_clear = in_bottom_switches[g];

    tspc_axis u_axis (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .target_in   (POSITION_BITS'(in_target_value)),
      .top_limit   (lim_r[g]),
      .drive_nxt   (drive_nxt[g]),
      .reached_nxt (reached_nxt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 1'b0;
      lim_r[0] <= TOP_RST_X;
      lim_r[1] <= TOP_RST_Y;
      lim_r[2] <= TOP_RST_Z;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD:  hold_r   <= cfg_wdata[0];
        CFG_TOP_X: lim_r[0] <= LIMIT_W'(cfg_wdata);
        CFG_TOP_Y: lim_r[1] <= LIMIT_W'(cfg_wdata);
        CFG_TOP_Z: lim_r[2] <= LIMIT_W'(cfg_wdata);
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      drive_x_r     <= DRIVE_OFF;
      drive_y_r     <= DRIVE_OFF;
      drive_z_r     <= DRIVE_OFF;
      all_reached_r <= 1'b0;
      accepted_r    <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_r   <= 1'b1;
        drive_x_r     <= drive_nxt[0];
        drive_y_r     <= drive_nxt[1];
        drive_z_r     <= drive_nxt[2];
        all_reached_r <= &reached_nxt;
        accepted_r    <= set_ok;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_x         = drive_x_r;
  assign out_drive_y         = drive_y_r;
  assign out_drive_z         = drive_z_r;
  assign out_all_reached     = all_reached_r;
  assign out_target_accepted = accepted_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction did not fill output register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  a_tick_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_TICK) |=> !out_target_accepted)
    else $error("tick reported as accepted target");

  a_bad_axis_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_SET && in_axis == 2'd3) |=> !out_target_accepted)
    else $error("target for nonexistent axis accepted");

  a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_TICK && hold_r) |=>
      ($stable(out_drive_x) && $stable(out_drive_y) && $stable(out_drive_z)))
    else $error("held tick changed drive outputs");

endmodule
`default_nettype wire
